### src/ejfs_pkg.sv
// Shared types, constants and a helper function for the exon junction fragment splitter.
// Used by the front, queue, back and top-level modules; depends on nothing else.
`default_nettype none

package ejfs_pkg;

	// field widths
	localparam int COORD_W  = 31;
	localparam int CFG_W    = 16;
	localparam int STRAND_W = 2;

	// configuration register indexes
	localparam int    CFG_IDX_W      = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTRON = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_SIZE  = 1'b1;

	// reset values of the configuration registers
	localparam logic [CFG_W-1:0] MIN_INTRON_RST = 16'd20;
	localparam logic [CFG_W-1:0] SPAN_SIZE_RST  = 16'd100;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// result slots per transaction: two for the finished block, one for the end block
	localparam int NUM_SLOTS = 3;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_FIN_A = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT_FIN_B = 2'd1;
	localparam logic [SLOT_W-1:0] SLOT_END   = 2'd2;

	// piece operations
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_TAIL  = 2'd1,	// last span bases, opens a fragment
		OP_HEAD  = 2'd2,	// first span bases, closes a fragment
		OP_WHOLE = 2'd3		// whole block
	} op_t;

	// one queued command: everything the back needs to emit the pieces
	typedef struct packed {
		op_t [NUM_SLOTS-1:0]  ops;
		logic [COORD_W-1:0]   fin_left;
		logic [COORD_W-1:0]   fin_right;
		logic [COORD_W-1:0]   end_left;
		logic [COORD_W-1:0]   end_right;
		logic [STRAND_W-1:0]  strand;
	} cmd_t;

	// a span size of zero acts as one
	function automatic logic [CFG_W-1:0] span_eff(input logic [CFG_W-1:0] span);
		span_eff = (span == '0) ? CFG_W'(1) : span;
	endfunction

endpackage

`default_nettype wire

### src/ejfs_front.sv
// Front part: accepts exons, merges them into blocks and classifies finished and end blocks.
// Depends on ejfs_pkg; pushes one command per transaction that yields pieces.
`default_nettype none

module ejfs_front
	import ejfs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [COORD_W-1:0]  exon_left,
	input  wire logic [COORD_W-1:0]  exon_right,
	input  wire logic [STRAND_W-1:0] strand,
	input  wire logic                transcript_end,
	input  wire logic [CFG_W-1:0]    min_intron,
	input  wire logic [CFG_W-1:0]    span_size,
	output logic                     push,
	output cmd_t                     cmd
);

	logic [COORD_W-1:0] pend_left_q;
	logic [COORD_W-1:0] pend_right_q;
	logic               in_tx_q;
	logic               blk_fin_q;

	logic [CFG_W-1:0]   sp;
	logic [COORD_W+1:0] merge_lim;
	logic               merge;
	logic               finish;
	logic               fin_after;
	logic               pend_long;
	logic               end_long;
	logic               end_emit;
	logic [COORD_W-1:0] end_left;

	// length >= span, signed: right - left + 1 - span >= 0
	function automatic logic is_long(
		input logic [COORD_W-1:0] l,
		input logic [COORD_W-1:0] r,
		input logic [CFG_W-1:0]   s
	);
		logic [COORD_W+2:0] d;
		d = {3'b000, r} + (COORD_W+3)'(1) - {3'b000, l} - {{(COORD_W+3-CFG_W){1'b0}}, s};
		is_long = ~d[COORD_W+2];
	endfunction

	assign sp = span_eff(span_size);

	// gap below min_intron: left < pending_right + 1 + min_intron
	assign merge_lim = {2'b00, pend_right_q} + (COORD_W+2)'(1)
		+ {{(COORD_W+2-CFG_W){1'b0}}, min_intron};
	assign merge     = in_tx_q && ({2'b00, exon_left} < merge_lim);
	assign finish    = in_tx_q && !merge;
	assign fin_after = in_tx_q && (blk_fin_q || finish);

	// block that is pending after this exon, used when the transcript ends
	assign end_left  = merge ? pend_left_q : exon_left;
	assign pend_long = is_long(pend_left_q, pend_right_q, sp);
	assign end_long  = is_long(end_left, exon_right, sp);
	assign end_emit  = transcript_end && fin_after;

	// classify into piece slots
	always_comb begin
		cmd.ops       = {NUM_SLOTS{OP_NONE}};
		cmd.fin_left  = pend_left_q;
		cmd.fin_right = pend_right_q;
		cmd.end_left  = end_left;
		cmd.end_right = exon_right;
		cmd.strand    = strand;
		if (finish) begin
			if (!blk_fin_q) begin
				cmd.ops[SLOT_FIN_A] = OP_TAIL;
			end else if (pend_long) begin
				cmd.ops[SLOT_FIN_A] = OP_HEAD;
				cmd.ops[SLOT_FIN_B] = OP_TAIL;
			end else begin
				cmd.ops[SLOT_FIN_A] = OP_WHOLE;
			end
		end
		if (end_emit) begin
			cmd.ops[SLOT_END] = end_long ? OP_HEAD : OP_WHOLE;
		end
	end

	assign push = accept && (finish || end_emit);

	// transcript state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_left_q  <= '0;
			pend_right_q <= '0;
			in_tx_q      <= 1'b0;
			blk_fin_q    <= 1'b0;
		end else if (accept) begin
			if (merge) begin
				pend_right_q <= exon_right;
			end else begin
				pend_left_q  <= exon_left;
				pend_right_q <= exon_right;
			end
			in_tx_q   <= !transcript_end;
			blk_fin_q <= !transcript_end && fin_after;
		end
	end

endmodule

`default_nettype wire

### src/ejfs_queue.sv
// Short command queue between the front and back parts.
// Depends on ejfs_pkg for the command type and depth.
`default_nettype none

module ejfs_queue
	import ejfs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty,
	output logic      full
);

	cmd_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W:0] wr_ptr_q;
	logic [QPTR_W:0] rd_ptr_q;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[QPTR_W] != rd_ptr_q[QPTR_W])
		&& (wr_ptr_q[QPTR_W-1:0] == rd_ptr_q[QPTR_W-1:0]);
	assign head  = entry_q[rd_ptr_q[QPTR_W-1:0]];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q[QPTR_W-1:0]] <= push_cmd;
		end
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + (QPTR_W+1)'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + (QPTR_W+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

### src/ejfs_back.sv
// Back part: walks the piece slots of the head command and emits one piece per cycle while not stalled.
// Depends on ejfs_pkg; drives the output register of the piece channel.
`default_nettype none

module ejfs_back
	import ejfs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  cmd_t                     head,
	input  wire logic                empty,
	output logic                     pop,
	input  wire logic [CFG_W-1:0]    span_size,
	output logic                     piece_valid,
	input  wire logic                piece_stall,
	output logic [COORD_W-1:0]       piece_left,
	output logic [COORD_W-1:0]       piece_right,
	output logic [STRAND_W-1:0]      piece_strand,
	output logic                     opens_fragment,
	output logic                     closes_fragment,
	output logic                     last_of_run
);

	logic [NUM_SLOTS-1:0] done_q;
	logic [NUM_SLOTS-1:0] used;
	logic [NUM_SLOTS-1:0] active;
	logic [NUM_SLOTS-1:0] pick;
	logic                 last;
	logic [SLOT_W-1:0]    slot;
	op_t                  op;
	logic                 load;
	logic [CFG_W-1:0]     sp;
	logic [COORD_W-1:0]   blk_l;
	logic [COORD_W-1:0]   blk_r;
	logic [COORD_W+2:0]   tail_t;
	logic [COORD_W:0]     head_t;
	logic [COORD_W-1:0]   tail_left;
	logic [COORD_W-1:0]   head_right;
	logic [COORD_W-1:0]   res_l;
	logic [COORD_W-1:0]   res_r;
	logic                 res_open;
	logic                 res_close;

	// pending slots of the head command, lowest first
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			used[i] = (head.ops[i] != OP_NONE);
		end
	end
	assign active = used & ~done_q;
	assign pick   = active & (~active + NUM_SLOTS'(1));
	assign last   = ((active & ~pick) == '0);

	always_comb begin
		slot = SLOT_FIN_A;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (pick[i]) begin
				slot = SLOT_W'(i);
			end
		end
	end

	assign op    = head.ops[slot];
	assign blk_l = (slot == SLOT_END) ? head.end_left  : head.fin_left;
	assign blk_r = (slot == SLOT_END) ? head.end_right : head.fin_right;

	// tail: max(right - span + 1, left); head: min(left + span - 1, right)
	assign sp         = span_eff(span_size);
	assign tail_t     = {3'b000, blk_r} - {{(COORD_W+3-CFG_W){1'b0}}, sp} + (COORD_W+3)'(1);
	assign tail_left  = ($signed(tail_t) > $signed({3'b000, blk_l})) ?
		tail_t[COORD_W-1:0] : blk_l;
	assign head_t     = {1'b0, blk_l} + {{(COORD_W+1-CFG_W){1'b0}}, sp} - (COORD_W+1)'(1);
	assign head_right = (head_t < {1'b0, blk_r}) ? head_t[COORD_W-1:0] : blk_r;

	// piece decode
	always_comb begin
		res_l     = blk_l;
		res_r     = blk_r;
		res_open  = 1'b0;
		res_close = 1'b0;
		unique case (op)
			OP_TAIL: begin
				res_l    = tail_left;
				res_open = 1'b1;
			end
			OP_HEAD: begin
				res_r     = head_right;
				res_close = 1'b1;
			end
			OP_WHOLE: begin
				res_close = (slot == SLOT_END);
			end
			default: begin
				res_open  = 1'b0;
				res_close = 1'b0;
			end
		endcase
	end

	assign load = !empty && (!piece_valid || !piece_stall);
	assign pop  = load && last;

	// slot progress within the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (load) begin
			done_q <= last ? '0 : (done_q | pick);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piece_valid <= 1'b0;
		end else if (load) begin
			piece_valid <= 1'b1;
		end else if (!piece_stall) begin
			piece_valid <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			piece_left      <= res_l;
			piece_right     <= res_r;
			piece_strand    <= head.strand;
			opens_fragment  <= res_open;
			closes_fragment <= res_close;
			last_of_run     <= last;
		end
	end

endmodule

`default_nettype wire

### src/exon_junction_fragment_splitter.sv
// Exon junction fragment splitter, top level: configuration registers, front, queue, back.
// A piece passes the command queue and then the output register before it is valid.
// Throughput: one exon per cycle at the front, one piece per cycle at the back while
// piece_stall is low; an exon gives zero to three pieces.
// The four-entry command queue absorbs bursts; the front stalls only when it is full.
// Reset (arst_n low) clears the transcript state and queue and loads min_intron 20, span 100.
`default_nettype none

module exon_junction_fragment_splitter
	import ejfs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 exon_valid,
	output logic                      exon_stall,
	input  wire logic [COORD_W-1:0]   exon_left,
	input  wire logic [COORD_W-1:0]   exon_right,
	input  wire logic [STRAND_W-1:0]  strand,
	input  wire logic                 transcript_end,
	output logic                      piece_valid,
	input  wire logic                 piece_stall,
	output logic [COORD_W-1:0]        piece_left,
	output logic [COORD_W-1:0]        piece_right,
	output logic [STRAND_W-1:0]       piece_strand,
	output logic                      opens_fragment,
	output logic                      closes_fragment,
	output logic                      last_of_run,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] min_intron_q;
	logic [CFG_W-1:0] span_size_q;
	logic             accept;
	logic             push;
	cmd_t             push_cmd;
	cmd_t             head;
	logic             pop;
	logic             empty;
	logic             full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_intron_q <= MIN_INTRON_RST;
			span_size_q  <= SPAN_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_INTRON: min_intron_q <= cfg_data;
				REG_SPAN_SIZE:  span_size_q  <= cfg_data;
				default:        min_intron_q <= min_intron_q;
			endcase
		end
	end

	assign exon_stall = full;
	assign accept     = exon_valid && !exon_stall;

	ejfs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.exon_left      (exon_left),
		.exon_right     (exon_right),
		.strand         (strand),
		.transcript_end (transcript_end),
		.min_intron     (min_intron_q),
		.span_size      (span_size_q),
		.push           (push),
		.cmd            (push_cmd)
	);

	ejfs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	ejfs_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.empty           (empty),
		.pop             (pop),
		.span_size       (span_size_q),
		.piece_valid     (piece_valid),
		.piece_stall     (piece_stall),
		.piece_left      (piece_left),
		.piece_right     (piece_right),
		.piece_strand    (piece_strand),
		.opens_fragment  (opens_fragment),
		.closes_fragment (closes_fragment),
		.last_of_run     (last_of_run)
	);

endmodule

`default_nettype wire

### src/ejfs_checker.sv
// Port-level checker for the exon junction fragment splitter, bound to the top level.
// Depends on ejfs_pkg for field widths.
`default_nettype none

module ejfs_checker
	import ejfs_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                piece_valid,
	input wire logic                piece_stall,
	input wire logic [COORD_W-1:0]  piece_left,
	input wire logic [COORD_W-1:0]  piece_right,
	input wire logic [STRAND_W-1:0] piece_strand,
	input wire logic                opens_fragment,
	input wire logic                closes_fragment,
	input wire logic                last_of_run
);

	// a stalled piece stays valid and keeps its coordinates, strand and last_of_run
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		piece_valid && piece_stall |=> piece_valid && $stable(piece_left)
			&& $stable(piece_right) && $stable(piece_strand)
			&& $stable(last_of_run))
		else $error("stalled piece changed");

	// a piece never both opens and closes a fragment
	a_open_close: assert property (@(posedge clk) disable iff (!arst_n)
		piece_valid |-> !(opens_fragment && closes_fragment))
		else $error("piece opens and closes a fragment");

	// the pieces of one transaction follow without a gap
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		piece_valid && !piece_stall && !last_of_run |=> piece_valid)
		else $error("gap inside a run of pieces");

endmodule

bind exon_junction_fragment_splitter ejfs_checker u_ejfs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.piece_valid     (piece_valid),
	.piece_stall     (piece_stall),
	.piece_left      (piece_left),
	.piece_right     (piece_right),
	.piece_strand    (piece_strand),
	.opens_fragment  (opens_fragment),
	.closes_fragment (closes_fragment),
	.last_of_run     (last_of_run)
);

`default_nettype wire
